// ----- rtl/core/dkpq_pkg.sv -----
// Shared types and codes for the dual-key priority packet queue.
`timescale 1ns / 1ps
`default_nettype none

package dkpq_pkg;

  // Field widths fixed by the descriptor format.
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned CLASS_W  = 8;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 7;

  // Request kinds.
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_STORED       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STORED_EVICT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DEQ_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd5;

  // Incoming request.
  typedef struct packed {
    logic                mode;
    logic [HANDLE_W-1:0] packet_id;
    logic [CLASS_W-1:0]  service_class;
    logic [LENGTH_W-1:0] packet_length;
    logic                make_room;
  } req_t;

  // Outgoing result.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_id;
    logic [HANDLE_W-1:0] evicted_id;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  // One stored descriptor.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [CLASS_W-1:0]  svc_class;
    logic [LENGTH_W-1:0] length;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/dual_key_priority_packet_queue_top.sv -----
// Top level of the dual-key priority packet queue: sequencer and result register.
//
// Usage: a request on in_valid/in_ready carries one packet descriptor.
// mode 0 enqueues it; with make_room set, the oldest entry holding the
// largest service_class is evicted first and its handle reported. mode 1
// dequeues the oldest entry holding the largest packet_length. Each
// request produces exactly one result on out_valid/out_ready.
// Entries sit in a single-port-read memory in arrival order, oldest at
// slot 0. A request that needs a search reads every stored entry through
// one shared compare unit, one entry per cycle, then closes the gap by
// copying the younger entries down one slot, again one per cycle.
// Empty-store and full answers go straight to the result step, and a plain store
// passes through the append step first; a search runs scan, pick, the copy when a
// younger entry exists, remove and, for an eviction, append before the result step.
// in_ready is high only while the sequencer is idle. The result sits in an
// output register, so the next request is accepted while the previous
// result still waits; a stalled receiver holds the sequencer at its last
// step until the register frees up.
// Reset empties the queue at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module dual_key_priority_packet_queue_top
  import dkpq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_REMOVE,
    S_APPEND,
    S_FINISH
  } state_t;

  state_t                state;
  req_t                  item;
  logic [STATUS_W-1:0]   status;
  logic [HANDLE_W-1:0]   res_handle;
  logic [CW-1:0]         count;
  logic [AW-1:0]         idx;
  logic                  issuing;
  logic                  pend_valid;
  logic [AW-1:0]         pend_slot;

  logic                  issue;
  logic [AW-1:0]         last_slot;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  entry_t                wr_data;
  entry_t                rd_data;
  logic                  cand_valid;
  logic                  cand_first;
  logic [KEY_W-1:0]      cand_key;
  logic [AW-1:0]         best_slot;
  logic [HANDLE_W-1:0]   best_handle;

  // Slot of the youngest stored entry.
  assign last_slot = AW'(count - CW'(1));
  assign in_ready  = (state == S_IDLE);

  // Memory read issue during the scan and the gap-closing copy.
  assign issue = ((state == S_SCAN) || (state == S_SHIFT)) && issuing;

  // Candidate for the compare unit: the key picked by the request kind.
  assign cand_valid = (state == S_SCAN) && pend_valid;
  assign cand_first = (pend_slot == '0);
  assign cand_key   = (item.mode == MODE_DEQ) ? rd_data.length
                                              : {{(KEY_W - CLASS_W){1'b0}}, rd_data.svc_class};

  // Memory writes: copy one slot down, or append the new descriptor.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_slot - AW'(1);
    wr_data = rd_data;
    if (state == S_APPEND) begin
      wr_en             = 1'b1;
      wr_addr           = AW'(count);
      wr_data.handle    = item.packet_id;
      wr_data.svc_class = item.service_class;
      wr_data.length    = item.packet_length;
    end else if ((state == S_SHIFT) && pend_valid) begin
      wr_en = 1'b1;
    end
  end

  dkpq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  dkpq_max_unit #(
    .AW (AW)
  ) u_max (
    .clk         (clk),
    .cand_valid  (cand_valid),
    .cand_first  (cand_first),
    .cand_slot   (pend_slot),
    .cand_handle (rd_data.handle),
    .cand_key    (cand_key),
    .best_slot   (best_slot),
    .best_handle (best_handle)
  );

  // Sequencer, address counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      count      <= '0;
      issuing    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      // A taken result frees the register unless the last step refills it.
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      // Read pipeline: data for the slot issued now arrives next cycle.
      pend_valid <= issue;
      pend_slot  <= idx;
      if (issue) begin
        if (idx == last_slot) begin
          issuing <= 1'b0;
        end else begin
          idx <= idx + AW'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item       <= in_data;
            res_handle <= '0;
            if (in_data.mode == MODE_DEQ) begin
              if (count == '0) begin
                status <= ST_DEQ_EMPTY;
                state  <= S_FINISH;
              end else begin
                status  <= ST_DEQUEUED;
                idx     <= '0;
                issuing <= 1'b1;
                state   <= S_SCAN;
              end
            end else if (in_data.make_room) begin
              if (count == '0) begin
                status <= ST_EVICT_EMPTY;
                state  <= S_FINISH;
              end else begin
                status  <= ST_STORED_EVICT;
                idx     <= '0;
                issuing <= 1'b1;
                state   <= S_SCAN;
              end
            end else if (count >= CW'(DEPTH)) begin
              status <= ST_FULL;
              state  <= S_FINISH;
            end else begin
              status <= ST_STORED;
              state  <= S_APPEND;
            end
          end
        end
        S_SCAN: begin
          if (pend_valid && (pend_slot == last_slot)) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          res_handle <= best_handle;
          if (best_slot == last_slot) begin
            state <= S_REMOVE;
          end else begin
            idx     <= best_slot + AW'(1);
            issuing <= 1'b1;
            state   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (pend_valid && (pend_slot == last_slot)) begin
            state <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          count <= count - CW'(1);
          state <= (item.mode == MODE_DEQ) ? S_FINISH : S_APPEND;
        end
        S_APPEND: begin
          count <= count + CW'(1);
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.status     <= status;
            out_data.out_id     <= (status == ST_DEQUEUED) ? res_handle : '0;
            out_data.evicted_id <= (status == ST_STORED_EVICT) ? res_handle : '0;
            out_data.occupancy  <= OCC_W'(count);
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dkpq_store.sv -----
// Descriptor memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dkpq_store
  import dkpq_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dkpq_max_unit.sv -----
// Shared compare unit that tracks the oldest entry holding the largest key.
`timescale 1ns / 1ps
`default_nettype none

module dkpq_max_unit
  import dkpq_pkg::*;
#(
  parameter int unsigned AW = 6
) (
  input  wire logic                clk,
  input  wire logic                cand_valid,
  input  wire logic                cand_first,
  input  wire logic [AW-1:0]       cand_slot,
  input  wire logic [HANDLE_W-1:0] cand_handle,
  input  wire logic [KEY_W-1:0]    cand_key,
  output logic [AW-1:0]            best_slot,
  output logic [HANDLE_W-1:0]      best_handle
);

  logic [KEY_W-1:0] best_key;
  logic             take;

  // Only a strictly larger key replaces the best, so the oldest wins ties.
  assign take = cand_valid && (cand_first || (cand_key > best_key));

  always_ff @(posedge clk) begin
    if (take) begin
      best_key    <= cand_key;
      best_slot   <= cand_slot;
      best_handle <= cand_handle;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dkpq_checker.sv -----
// Port-level checker for the dual-key priority packet queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dkpq_checker
  import dkpq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire req_t in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire rsp_t out_data
);

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  // A pending result is held until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // One request at a time: an accepted request blocks the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one is in flight");

  // Empty-queue answers report an empty queue.
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_data.status == ST_DEQ_EMPTY) || (out_data.status == ST_EVICT_EMPTY))
    |-> (out_data.occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // A full rejection reports a full queue.
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_FULL) |-> (out_data.occupancy == FULL_OCC))
    else $error("full status with wrong occupancy");

endmodule

bind dual_key_priority_packet_queue_top dkpq_checker #(
  .DEPTH (DEPTH)
) u_dkpq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
